// ----- hw/rtl/lqrs_pkg.sv -----
// Shared constants, codes and beat types for the root solver.
package lqrs_pkg;

	// Queue between front and back
	localparam int unsigned FIFO_DEPTH = 4;

	// Datapath widths
	localparam int unsigned COEF_W    = 32;
	localparam int unsigned DISC_W    = 67;
	localparam int unsigned SQRT_BITS = 35;
	localparam int unsigned NUM_W     = 36;
	localparam int unsigned FRAC_BITS = 16;
	localparam int unsigned REM_W     = NUM_W + FRAC_BITS;
	localparam int unsigned DEN_W     = 33;
	localparam int unsigned QUO_BITS  = 33;

	// Result kinds
	localparam logic [2:0] KIND_NONE  = 3'd0;
	localparam logic [2:0] KIND_ONE   = 3'd1;
	localparam logic [2:0] KIND_TWO   = 3'd2;
	localparam logic [2:0] KIND_INF   = 3'd3;
	localparam logic [2:0] KIND_DEGEN = 3'd4;

	// Saturation limits of a quotient magnitude
	localparam logic [QUO_BITS-1:0] POS_LIMIT = 33'h0_7FFF_FFFF;
	localparam logic [QUO_BITS-1:0] NEG_LIMIT = 33'h0_8000_0000;

	// Fields that ride along every square root stage of the back end
	typedef struct packed {
		logic [2:0]              kind;
		logic signed [COEF_W-1:0] b;
		logic signed [DEN_W-1:0]  den;
	} tag_t;

	// Classified item from the front end
	typedef struct packed {
		tag_t              tag;
		logic [DISC_W-1:0] disc;
	} fitem_t;

	// Item after the square root
	typedef struct packed {
		tag_t                 tag;
		logic [SQRT_BITS-1:0] root;
	} sitem_t;

	// Item after both divisions: quotient magnitudes and flags per root
	typedef struct packed {
		logic [2:0]          kind;
		logic [QUO_BITS-1:0] qm;
		logic [QUO_BITS-1:0] qp;
		logic                negm;
		logic                negp;
		logic                ovfm;
		logic                ovfp;
	} ditem_t;

endpackage

// ----- hw/rtl/linear_quadratic_root_solver.sv -----
// Top level of the linear / quadratic root solver in signed Q16.16.
//
// Accepts one coefficient set per clock while s_tready is high and returns one
// result beat per set, in order. A beat passes the front end (products, then
// discriminant and class), the queue, 35 square root stages (one root bit
// each), one numerator stage, 33 divider stages (one quotient bit each) and
// the output register. The queue of FIFO_DEPTH beats
// lets the front end keep accepting while the back end is held by m_tready;
// s_tready falls only once that queue is full. No reset sweep is needed.
module linear_quadratic_root_solver import lqrs_pkg::*; #(
	parameter int unsigned FifoDepth = FIFO_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // coef_a [31:0], coef_b [63:32], coef_c [95:64]
	input  logic [0:0]  s_tuser,   // action [0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // root_minus [31:0], root_plus [63:32]
	output logic [3:0]  m_tuser    // root_kind [2:0], saturated [3]
);

	logic   push, full, empty, pop, en;
	fitem_t f_item, q_item;
	logic   s_valid, d_valid;
	sitem_t s_item;
	ditem_t d_item;

	logic                out_v_q;
	logic [2:0]          kind_q;
	logic [COEF_W-1:0]   rm_q, rp_q;
	logic                sat_q;

	logic [COEF_W-1:0]   rm_c, rp_c;
	logic                satm_c, satp_c, sat_c;

	lqrs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.action   (s_tuser[0]),
		.coef_a   ($signed(s_tdata[31:0])),
		.coef_b   ($signed(s_tdata[63:32])),
		.coef_c   ($signed(s_tdata[95:64])),
		.push     (push),
		.item     (f_item),
		.full     (full)
	);

	lqrs_fifo #(.DEPTH(FifoDepth)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (f_item),
		.full   (full),
		.pop    (pop),
		.dout   (q_item),
		.empty  (empty)
	);

	// Back end moves whenever the output register can take a beat
	assign en  = !out_v_q || m_tready;
	assign pop = en && !empty;

	lqrs_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (pop),
		.in_item   (q_item),
		.out_valid (s_valid),
		.out_item  (s_item)
	);

	lqrs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_valid),
		.in_item   (s_item),
		.out_valid (d_valid),
		.out_item  (d_item)
	);

	// Clamp each quotient and apply its sign
	assign satm_c = d_item.ovfm || (d_item.negm ? (d_item.qm > NEG_LIMIT)
	                                            : (d_item.qm > POS_LIMIT));
	assign satp_c = d_item.ovfp || (d_item.negp ? (d_item.qp > NEG_LIMIT)
	                                            : (d_item.qp > POS_LIMIT));

	always_comb begin
		rm_c  = '0;
		rp_c  = '0;
		sat_c = 1'b0;
		case (d_item.kind)
			KIND_ONE: begin
				if (satm_c) begin
					rm_c = d_item.negm ? NEG_LIMIT[COEF_W-1:0] : POS_LIMIT[COEF_W-1:0];
				end else begin
					rm_c = d_item.negm ? -d_item.qm[COEF_W-1:0] : d_item.qm[COEF_W-1:0];
				end
				sat_c = satm_c;
			end
			KIND_TWO: begin
				if (satm_c) begin
					rm_c = d_item.negm ? NEG_LIMIT[COEF_W-1:0] : POS_LIMIT[COEF_W-1:0];
				end else begin
					rm_c = d_item.negm ? -d_item.qm[COEF_W-1:0] : d_item.qm[COEF_W-1:0];
				end
				if (satp_c) begin
					rp_c = d_item.negp ? NEG_LIMIT[COEF_W-1:0] : POS_LIMIT[COEF_W-1:0];
				end else begin
					rp_c = d_item.negp ? -d_item.qp[COEF_W-1:0] : d_item.qp[COEF_W-1:0];
				end
				sat_c = satm_c || satp_c;
			end
			default: begin
				rm_c  = '0;
				rp_c  = '0;
				sat_c = 1'b0;
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= d_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_q <= d_item.kind;
			rm_q   <= rm_c;
			rp_q   <= rp_c;
			sat_q  <= sat_c;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {rp_q, rm_q};
	assign m_tuser  = {sat_q, kind_q};

	// Never write into a full queue
	assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("queue written while full");

	// Saturation only accompanies reported roots
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[3]) |-> (m_tuser[2:0] == KIND_ONE || m_tuser[2:0] == KIND_TWO))
		else $error("saturation flag without a root");

	// Second root field is zero unless two roots
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[2:0] != KIND_TWO) |-> (m_tdata[63:32] == '0))
		else $error("second root set without two roots");

	// A beat held at the output does not move the back end
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !pop)
		else $error("queue popped while output stalled");

endmodule

// ----- hw/rtl/lqrs_front.sv -----
// Front end: multiplies the coefficients, forms the discriminant and classifies the beat.
module lqrs_front import lqrs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     action,
	input  logic signed [COEF_W-1:0] coef_a,
	input  logic signed [COEF_W-1:0] coef_b,
	input  logic signed [COEF_W-1:0] coef_c,
	output logic                     push,
	output fitem_t                   item,
	input  logic                     full
);

	logic                      adv;
	logic                      v_s1, v_s2;
	logic                      action_s1;
	logic signed [COEF_W-1:0]  a_s1, b_s1;
	logic signed [2*COEF_W-1:0] bb_s1, ac_s1;
	logic signed [2*COEF_W-1:0] bb, ac;
	logic signed [DISC_W:0]    disc_full;
	fitem_t                    nxt, item_s2;

	// Advance unless the classified beat cannot enter the queue
	assign adv      = !(v_s2 && full);
	assign in_ready = adv;
	assign push     = v_s2 && !full;
	assign item     = item_s2;

	// Products of the coefficients
	assign bb = (2*COEF_W)'(coef_b) * (2*COEF_W)'(coef_b);
	assign ac = (2*COEF_W)'(coef_a) * (2*COEF_W)'(coef_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			action_s1 <= action;
			a_s1      <= coef_a;
			b_s1      <= coef_b;
			bb_s1     <= bb;
			ac_s1     <= ac;
			item_s2   <= nxt;
		end
	end

	// Discriminant b*b - 4ac, exact
	assign disc_full = (DISC_W+1)'(bb_s1) - ((DISC_W+1)'(ac_s1) <<< 2);

	// Classify the beat
	always_comb begin
		nxt.tag.b    = b_s1;
		nxt.disc     = '0;
		nxt.tag.den  = DEN_W'(a_s1);
		nxt.tag.kind = KIND_NONE;
		if (!action_s1) begin
			if (a_s1 != '0) begin
				nxt.tag.kind = KIND_ONE;
			end else if (b_s1 == '0) begin
				nxt.tag.kind = KIND_INF;
			end else begin
				nxt.tag.kind = KIND_NONE;
			end
		end else begin
			nxt.tag.den = {a_s1, 1'b0};
			if (a_s1 == '0) begin
				nxt.tag.kind = KIND_DEGEN;
			end else if (disc_full < 0) begin
				nxt.tag.kind = KIND_NONE;
			end else if (disc_full == '0) begin
				nxt.tag.kind = KIND_ONE;
			end else begin
				nxt.tag.kind = KIND_TWO;
				nxt.disc     = disc_full[DISC_W-1:0];
			end
		end
	end

endmodule

// ----- hw/rtl/lqrs_fifo.sv -----
// Short queue between the front end and the back end.
module lqrs_fifo import lqrs_pkg::*; #(
	parameter int unsigned DEPTH = FIFO_DEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  fitem_t din,
	output logic   full,
	input  logic   pop,
	output fitem_t dout,
	output logic   empty
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	fitem_t          mem_q [DEPTH];
	logic [AW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rd_q];

	// Store the incoming beat
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/lqrs_sqrt.sv -----
// Pipelined floor square root of the discriminant, one root bit per stage.
module lqrs_sqrt import lqrs_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   in_valid,
	input  fitem_t in_item,
	output logic   out_valid,
	output sitem_t out_item
);

	localparam int unsigned RW = 2*SQRT_BITS + 2;

	logic                 v_q    [SQRT_BITS];
	logic [RW-1:0]        rem_q  [SQRT_BITS];
	logic [SQRT_BITS-1:0] root_q [SQRT_BITS];
	tag_t                 tag_q  [SQRT_BITS];

	for (genvar k = 0; k < SQRT_BITS; k++) begin : g_st
		localparam int unsigned J = SQRT_BITS - 1 - k;
		logic                 vi;
		logic [RW-1:0]        ri;
		logic [SQRT_BITS-1:0] si;
		tag_t                 ti;
		logic [RW-1:0]        term;

		if (k == 0) begin : g_in
			assign vi = in_valid;
			assign ri = RW'(in_item.disc);
			assign si = '0;
			assign ti = in_item.tag;
		end else begin : g_mid
			assign vi = v_q[k-1];
			assign ri = rem_q[k-1];
			assign si = root_q[k-1];
			assign ti = tag_q[k-1];
		end

		// (s + 2^J)^2 - s^2
		assign term = (RW'(si) << (J + 1)) + (RW'(1) << (2*J));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (en) begin
				v_q[k] <= vi;
			end
		end

		// Keep the trial bit when its square still fits
		always_ff @(posedge clk) begin
			if (en) begin
				tag_q[k] <= ti;
				if (ri >= term) begin
					rem_q[k]  <= ri - term;
					root_q[k] <= si | (SQRT_BITS'(1) << J);
				end else begin
					rem_q[k]  <= ri;
					root_q[k] <= si;
				end
			end
		end
	end

	assign out_valid     = v_q[SQRT_BITS-1];
	assign out_item.tag  = tag_q[SQRT_BITS-1];
	assign out_item.root = root_q[SQRT_BITS-1];

endmodule

// ----- hw/rtl/lqrs_div.sv -----
// Pipelined restoring division of both root numerators by the denominator.
module lqrs_div import lqrs_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   in_valid,
	input  sitem_t in_item,
	output logic   out_valid,
	output ditem_t out_item
);

	localparam int unsigned CW = DEN_W + QUO_BITS;

	logic signed [NUM_W-1:0] nb, rs;
	logic signed [NUM_W-1:0] num [2];
	logic [NUM_W-1:0]        nmag [2];
	logic [DEN_W-1:0]        dmag;
	logic [REM_W-1:0]        nsh [2];
	logic                    ovf [2];

	// Entry stage registers
	logic                    v_e;
	logic [2:0]              kind_e;
	logic [DEN_W-1:0]        dmag_e;
	logic [REM_W-1:0]        rem_e [2];
	logic                    neg_e [2];
	logic                    ovf_e [2];

	// Division stage registers
	logic                    v_q    [QUO_BITS];
	logic [2:0]              kind_q [QUO_BITS];
	logic [DEN_W-1:0]        dmag_q [QUO_BITS];
	logic [REM_W-1:0]        rem_q  [QUO_BITS][2];
	logic [QUO_BITS-1:0]     quo_q  [QUO_BITS][2];
	logic                    neg_q  [QUO_BITS][2];
	logic                    ovf_q  [QUO_BITS][2];

	// Form numerators -b - s and -b + s and their magnitudes
	assign nb     = -NUM_W'(in_item.tag.b);
	assign rs     = $signed({1'b0, in_item.root});
	assign num[0] = nb - rs;
	assign num[1] = nb + rs;
	assign dmag   = in_item.tag.den[DEN_W-1] ? DEN_W'(-in_item.tag.den)
	                                         : DEN_W'(in_item.tag.den);

	for (genvar l = 0; l < 2; l++) begin : g_lane
		assign nmag[l] = num[l][NUM_W-1] ? NUM_W'(-num[l]) : NUM_W'(num[l]);
		assign nsh[l]  = {nmag[l], {FRAC_BITS{1'b0}}};
		// Quotient would not fit the bits resolved below
		assign ovf[l]  = CW'(nsh[l]) >= {dmag, {QUO_BITS{1'b0}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_e <= 1'b0;
		end else if (en) begin
			v_e <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_e <= in_item.tag.kind;
			dmag_e <= dmag;
			for (int l = 0; l < 2; l++) begin
				rem_e[l] <= nsh[l];
				neg_e[l] <= num[l][NUM_W-1] ^ in_item.tag.den[DEN_W-1];
				ovf_e[l] <= ovf[l];
			end
		end
	end

	for (genvar k = 0; k < QUO_BITS; k++) begin : g_st
		localparam int unsigned J = QUO_BITS - 1 - k;
		logic                vi;
		logic [2:0]          ki;
		logic [DEN_W-1:0]    di;
		logic [REM_W-1:0]    ri [2];
		logic [QUO_BITS-1:0] qi [2];
		logic                ni [2];
		logic                oi [2];
		logic [CW-1:0]       dsh;

		if (k == 0) begin : g_in
			assign vi = v_e;
			assign ki = kind_e;
			assign di = dmag_e;
			for (genvar l = 0; l < 2; l++) begin : g_l
				assign ri[l] = rem_e[l];
				assign qi[l] = '0;
				assign ni[l] = neg_e[l];
				assign oi[l] = ovf_e[l];
			end
		end else begin : g_mid
			assign vi = v_q[k-1];
			assign ki = kind_q[k-1];
			assign di = dmag_q[k-1];
			for (genvar l = 0; l < 2; l++) begin : g_l
				assign ri[l] = rem_q[k-1][l];
				assign qi[l] = quo_q[k-1][l];
				assign ni[l] = neg_q[k-1][l];
				assign oi[l] = ovf_q[k-1][l];
			end
		end

		assign dsh = CW'(di) << J;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (en) begin
				v_q[k] <= vi;
			end
		end

		// Subtract the shifted divisor where it fits
		always_ff @(posedge clk) begin
			if (en) begin
				kind_q[k] <= ki;
				dmag_q[k] <= di;
				for (int l = 0; l < 2; l++) begin
					neg_q[k][l] <= ni[l];
					ovf_q[k][l] <= oi[l];
					if (CW'(ri[l]) >= dsh) begin
						rem_q[k][l] <= REM_W'(CW'(ri[l]) - dsh);
						quo_q[k][l] <= qi[l] | (QUO_BITS'(1) << J);
					end else begin
						rem_q[k][l] <= ri[l];
						quo_q[k][l] <= qi[l];
					end
				end
			end
		end
	end

	assign out_valid     = v_q[QUO_BITS-1];
	assign out_item.kind = kind_q[QUO_BITS-1];
	assign out_item.qm   = quo_q[QUO_BITS-1][0];
	assign out_item.qp   = quo_q[QUO_BITS-1][1];
	assign out_item.negm = neg_q[QUO_BITS-1][0];
	assign out_item.negp = neg_q[QUO_BITS-1][1];
	assign out_item.ovfm = ovf_q[QUO_BITS-1][0];
	assign out_item.ovfp = ovf_q[QUO_BITS-1][1];

endmodule

// ----- tb/linear_quadratic_root_solver_test.sv -----
// Self-checking bench for the root solver: directed table, then random coefficient sets.
module linear_quadratic_root_solver_test import lqrs_pkg::*;;

	localparam int N_RANDOM    = 1300;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic ACT_LIN   = 1'b0;
	localparam logic ACT_QUAD  = 1'b1;

	typedef struct {
		logic [2:0]         kind;
		logic signed [31:0] rm;
		logic signed [31:0] rp;
		logic               sat;
	} roots_t;

	typedef struct {
		logic               action;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [31:0] c;
		logic               typed;
		roots_t             res;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic [3:0]  m_tuser;

	roots_t pending_roots[$];
	int     n_errors = 0;
	int     n_received = 0;
	int     cycles = 0;

	linear_quadratic_root_solver i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #6 clk = ~clk;

	// Q16.16 quotient, truncated toward zero and clamped
	function automatic logic [31:0] fix_div(longint n, longint d, ref logic sat);
		logic        neg;
		logic [63:0] q;
		neg = (n < 0) != (d < 0);
		q = ((n < 0 ? -n : n) << 16) / (d < 0 ? -d : d);
		if (neg) begin
			if (q > 64'h8000_0000) begin
				q = 64'h8000_0000;
				sat = 1'b1;
			end
			return 32'(-q);
		end
		if (q > 64'h7FFF_FFFF) begin
			q = 64'h7FFF_FFFF;
			sat = 1'b1;
		end
		return q[31:0];
	endfunction

	function automatic roots_t solve_roots(logic action, logic signed [31:0] a,
			logic signed [31:0] b, logic signed [31:0] c);
		roots_t              r;
		logic signed [127:0] disc;
		logic [127:0]        t;
		longint              s, la, lb;
		r = '{kind: KIND_NONE, rm: 0, rp: 0, sat: 1'b0};
		la = a;
		lb = b;
		if (action == ACT_LIN) begin
			if (a != 0) begin
				r.kind = KIND_ONE;
				r.rm = fix_div(-lb, la, r.sat);
			end else
				r.kind = (b == 0) ? KIND_INF : KIND_NONE;
		end else if (a == 0) begin
			r.kind = KIND_DEGEN;
		end else begin
			disc = 128'(lb) * 128'(lb) - 128'sd4 * 128'(la) * 128'(c);
			if (disc == 0) begin
				r.kind = KIND_ONE;
				r.rm = fix_div(-lb, 2 * la, r.sat);
			end else if (disc > 0) begin
				s = 0;
				for (int i = 34; i >= 0; i--) begin
					t = 128'(s | (64'd1 << i));
					if (t * t <= 128'(disc)) s = longint'(t);
				end
				r.kind = KIND_TWO;
				r.rm = fix_div(-lb - s, 2 * la, r.sat);
				r.rp = fix_div(-lb + s, 2 * la, r.sat);
			end
		end
		return r;
	endfunction

	// Present one beat and hold it until accepted; predict on acceptance
	task automatic send_set(logic action, logic signed [31:0] a, logic signed [31:0] b,
			logic signed [31:0] c, logic typed, roots_t want);
		int gap;
		gap = $urandom_range(0, 14);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {c, b, a};
		s_tuser = action;
		do @(posedge clk); while (!s_tready);
		pending_roots.push_back(typed ? want : solve_roots(action, a, b, c));
		@(negedge clk);
	endtask

	row_t table_rows[] = '{
		'{ACT_LIN,  32'sd0, 32'sd0, 32'sd0, 1, '{KIND_INF, 0, 0, 0}},
		'{ACT_LIN,  32'sd0, 32'sd5, 32'sd9, 1, '{KIND_NONE, 0, 0, 0}},
		'{ACT_QUAD, 32'sd0, 32'sd7, 32'sd3, 1, '{KIND_DEGEN, 0, 0, 0}},
		'{ACT_LIN,  32'sh0001_0000, 32'sh8000_0000, 32'sd0, 1,
			'{KIND_ONE, 32'sh7FFF_FFFF, 0, 1}},
		'{ACT_LIN,  32'sh0001_0000, 32'sh7FFF_FFFF, 32'sd0, 1,
			'{KIND_ONE, 32'sh8000_0001, 0, 0}},
		'{ACT_LIN,  32'sh0001_0000, 32'sd0, 32'sh7FFF_FFFF, 1, '{KIND_ONE, 0, 0, 0}},
		'{ACT_LIN,  32'sd1, 32'sh7FFF_FFFF, 32'sd0, 0, '{KIND_NONE, 0, 0, 0}},
		'{ACT_LIN,  32'sh8000_0000, 32'sh8000_0000, 32'sd0, 0, '{KIND_NONE, 0, 0, 0}},
		'{ACT_LIN,  32'shFFFF_FFFF, 32'sh0000_0001, 32'sd0, 0, '{KIND_NONE, 0, 0, 0}},
		// no real roots: x^2 + 1
		'{ACT_QUAD, 32'sh0001_0000, 32'sd0, 32'sh0001_0000, 1, '{KIND_NONE, 0, 0, 0}},
		// double root: x^2 - 2x + 1
		'{ACT_QUAD, 32'sh0001_0000, 32'shFFFE_0000, 32'sh0001_0000, 0, '{KIND_NONE, 0, 0, 0}},
		// two roots: x^2 - 1
		'{ACT_QUAD, 32'sh0001_0000, 32'sd0, 32'shFFFF_0000, 0, '{KIND_NONE, 0, 0, 0}},
		// small positive discriminant: b*b - 4ac = 4
		'{ACT_QUAD, 32'sd1, 32'sd0, 32'shFFFF_FFFF, 0, '{KIND_NONE, 0, 0, 0}},
		'{ACT_QUAD, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, '{KIND_NONE, 0, 0, 0}},
		'{ACT_QUAD, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, '{KIND_NONE, 0, 0, 0}},
		'{ACT_QUAD, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, '{KIND_NONE, 0, 0, 0}},
		'{ACT_QUAD, 32'sd1, 32'sh7FFF_FFFF, 32'sd0, 0, '{KIND_NONE, 0, 0, 0}},
		'{ACT_QUAD, 32'shFFFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, '{KIND_NONE, 0, 0, 0}},
		'{ACT_QUAD, 32'sh7FFF_FFFF, 32'sd0, 32'sh7FFF_FFFF, 0, '{KIND_NONE, 0, 0, 0}}
	};

	// Cycle count and timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Compare each result beat with the oldest prediction
	always @(posedge clk) begin
		roots_t want;
		if (arst_n && m_tvalid && m_tready) begin
			n_received <= n_received + 1;
			if (pending_roots.size() == 0) begin
				n_errors++;
				if (n_errors <= 10) $display("unexpected result beat %h %h", m_tuser, m_tdata);
			end else begin
				want = pending_roots.pop_front();
				if (m_tuser[2:0] !== want.kind || m_tdata[31:0] !== want.rm ||
						m_tdata[63:32] !== want.rp || m_tuser[3] !== want.sat) begin
					n_errors++;
					if (n_errors <= 10)
						$display("mismatch: kind %0d/%0d minus %h/%h plus %h/%h sat %0d/%0d",
							want.kind, m_tuser[2:0], want.rm, m_tdata[31:0],
							want.rp, m_tdata[63:32], want.sat, m_tuser[3]);
				end
			end
		end
	end

	// Result side: random back-pressure, one long hold-off
	initial begin
		int w;
		bit held;
		held = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && n_received >= 300) begin
				held = 1;
				m_tready = 1'b0;
				repeat (400) @(negedge clk);
			end
			w = $urandom_range(0, 14);
			if ($urandom_range(0, 3) == 0) w = 0;
			if (w > 0) begin
				m_tready = 1'b0;
				repeat (w) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Stimulus
	initial begin
		logic               act;
		logic signed [31:0] a, b, c;
		int                 k, sel;
		roots_t             none;
		none = '{kind: KIND_NONE, rm: 0, rp: 0, sat: 1'b0};
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (table_rows[i])
			send_set(table_rows[i].action, table_rows[i].a, table_rows[i].b,
				table_rows[i].c, table_rows[i].typed, table_rows[i].res);
		for (int i = 0; i < N_RANDOM; i++) begin
			act = $urandom_range(0, 1);
			sel = $urandom_range(0, 9);
			a = $urandom;
			b = $urandom;
			c = $urandom;
			if (sel < 3) begin
				// modest magnitudes so that roots stay in range
				a = $signed(a) >>> $urandom_range(8, 24);
				b = $signed(b) >>> $urandom_range(4, 20);
				c = $signed(c) >>> $urandom_range(4, 20);
			end else if (sel == 3) begin
				// double root: b = 2ak, c = ak^2
				a = $urandom_range(1, 255);
				k = $urandom_range(0, 255);
				if ($urandom_range(0, 1)) a = -a;
				if ($urandom_range(0, 1)) k = -k;
				b = 2 * a * k;
				c = a * k * k;
				act = ACT_QUAD;
			end else if (sel == 4) begin
				if ($urandom_range(0, 1)) a = 0;
				if ($urandom_range(0, 1)) b = 0;
				if ($urandom_range(0, 1)) c = 0;
			end
			send_set(act, a, b, c, 1'b0, none);
		end
		s_tvalid = 1'b0;
		while (pending_roots.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (n_errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- linear_quadratic_root_solver.f -----
hw/rtl/lqrs_pkg.sv
hw/rtl/lqrs_front.sv
hw/rtl/lqrs_fifo.sv
hw/rtl/lqrs_sqrt.sv
hw/rtl/lqrs_div.sv
hw/rtl/linear_quadratic_root_solver.sv
tb/linear_quadratic_root_solver_test.sv
